// File: hw/rtl/ppu_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppu_pkg
// Shared types and constants of the particle pool update block.
// ---------------------------------------------------------------------------
package ppu_pkg;

  localparam int POOL_DEF    = 1024;
  localparam int Q_W         = 32;
  localparam int TS_W        = 16;
  localparam int LIFE_W      = 31;
  localparam int SLOT_W      = 10;
  localparam int COUNT_W     = 11;
  localparam int PROD_W      = Q_W + TS_W + 1;

  // angle step = floor(ts / 100) = (ts * 83887) >> 23 for any 16-bit ts
  localparam int ANG_RECIP_W = 17;
  localparam logic [ANG_RECIP_W-1:0] ANG_RECIP = 17'd83887;
  localparam int ANG_SHIFT   = 23;
  localparam int ANG_STEP_W  = 10;

  localparam logic [Q_W-1:0] PI_Q16 = 32'd205887;

  localparam logic REQ_EMIT = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic           alive;
    logic [Q_W-1:0] life;
    logic [Q_W-1:0] pos_x;
    logic [Q_W-1:0] pos_y;
    logic [Q_W-1:0] spd_x;
    logic [Q_W-1:0] spd_y;
    logic [Q_W-1:0] angle;
  } particle_t;

  localparam int REC_W = $bits(particle_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EMIT_RD,
    ST_EMIT_WR,
    ST_TICK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // sequencer to update pipeline
  typedef struct packed {
    logic                  lookup;
    logic [TS_W-1:0]       ts;
    logic [ANG_STEP_W-1:0] ang_step;
  } upd_cmd_t;

  // update pipeline to sequencer
  typedef struct packed {
    logic wr;
    logic retire;
    logic busy;
  } upd_stat_t;

endpackage

// File: hw/rtl/ppu_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppu_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module ppu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/ppu_update.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppu_update
// Two-stage particle step: multiply, then saturating add and write-back.
// ---------------------------------------------------------------------------
module ppu_update #(
  parameter int POOL = ppu_pkg::POOL_DEF,
  localparam int PTR_W = $clog2(POOL)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ppu_pkg::upd_cmd_t   cmd,
  input  logic [PTR_W-1:0]    addr,
  input  ppu_pkg::particle_t  rd_data,
  output ppu_pkg::upd_stat_t  stat,
  output logic [PTR_W-1:0]    waddr,
  output ppu_pkg::particle_t  wdata
);

  import ppu_pkg::*;

  logic                     s1_valid_r;
  logic                     s1_kill_r;
  logic [PTR_W-1:0]         s1_addr_r;
  logic [Q_W-1:0]           s1_life_r;
  logic [Q_W-1:0]           s1_posx_r;
  logic [Q_W-1:0]           s1_posy_r;
  logic [Q_W-1:0]           s1_spdx_r;
  logic [Q_W-1:0]           s1_spdy_r;
  logic [Q_W-1:0]           s1_ang_r;
  logic signed [PROD_W-1:0] s1_prodx_r;
  logic signed [PROD_W-1:0] s1_prody_r;

  logic signed [TS_W:0]     ts_s;
  logic signed [PROD_W-1:0] prodx_nxt;
  logic signed [PROD_W-1:0] prody_nxt;
  logic                     kill_nxt;
  particle_t                rec;

  function automatic logic [Q_W-1:0] sat_add(logic [Q_W-1:0] pos,
                                             logic [PROD_W-1:0] prod);
    logic [Q_W+1:0] sum;
    sum = {{2{pos[Q_W-1]}}, pos} + {prod[PROD_W-1], prod[PROD_W-1:TS_W]};
    if (sum[Q_W+1:Q_W-1] == 3'b000 || sum[Q_W+1:Q_W-1] == 3'b111) begin
      return sum[Q_W-1:0];
    end
    return sum[Q_W+1] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
  endfunction

  assign ts_s      = $signed({1'b0, cmd.ts});
  assign prodx_nxt = $signed(rd_data.spd_x) * ts_s;
  assign prody_nxt = $signed(rd_data.spd_y) * ts_s;
  assign kill_nxt  = rd_data.life[Q_W-1] || (rd_data.life == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd.lookup && rd_data.alive;
    end
  end

  always_ff @(posedge clk) begin
    s1_kill_r  <= kill_nxt;
    s1_addr_r  <= addr;
    s1_life_r  <= rd_data.life - {{(Q_W-TS_W){1'b0}}, cmd.ts};
    s1_posx_r  <= rd_data.pos_x;
    s1_posy_r  <= rd_data.pos_y;
    s1_spdx_r  <= rd_data.spd_x;
    s1_spdy_r  <= rd_data.spd_y;
    s1_ang_r   <= rd_data.angle + {{(Q_W-ANG_STEP_W){1'b0}}, cmd.ang_step};
    s1_prodx_r <= prodx_nxt;
    s1_prody_r <= prody_nxt;
  end

  always_comb begin
    rec = '0;
    if (!s1_kill_r) begin
      rec.alive = 1'b1;
      rec.life  = s1_life_r;
      rec.pos_x = sat_add(s1_posx_r, s1_prodx_r);
      rec.pos_y = sat_add(s1_posy_r, s1_prody_r);
      rec.spd_x = s1_spdx_r;
      rec.spd_y = s1_spdy_r;
      rec.angle = s1_ang_r;
    end
  end

  assign stat.wr     = s1_valid_r;
  assign stat.retire = s1_valid_r && s1_kill_r;
  assign stat.busy   = s1_valid_r;
  assign waddr       = s1_addr_r;
  assign wdata       = rec;

endmodule

// File: hw/rtl/ppu_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppu_ctrl
// Sequencer: clearing pass, emit read-modify-write, tick sweep, live count
// and result register.
// ---------------------------------------------------------------------------
module ppu_ctrl #(
  parameter int POOL = ppu_pkg::POOL_DEF,
  localparam int PTR_W = $clog2(POOL)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_req_type,
  input  logic [ppu_pkg::TS_W-1:0]  in_timestep,
  input  logic [ppu_pkg::Q_W-1:0]   in_pos_x,
  input  logic [ppu_pkg::Q_W-1:0]   in_pos_y,
  input  logic [ppu_pkg::Q_W-1:0]   in_spread_x,
  input  logic [ppu_pkg::Q_W-1:0]   in_spread_y,
  input  logic [ppu_pkg::LIFE_W-1:0] in_life_span,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ppu_pkg::SLOT_W-1:0]  out_slot_written,
  output logic [ppu_pkg::COUNT_W-1:0] out_live_count,
  output logic                      ram_we,
  output logic [PTR_W-1:0]          ram_waddr,
  output ppu_pkg::particle_t        ram_wdata,
  output logic                      ram_re,
  output logic [PTR_W-1:0]          ram_raddr,
  input  ppu_pkg::particle_t        ram_rdata,
  output ppu_pkg::upd_cmd_t         upd_cmd,
  output logic [PTR_W-1:0]          upd_addr,
  input  ppu_pkg::upd_stat_t        upd_stat,
  input  logic [PTR_W-1:0]          upd_waddr,
  input  ppu_pkg::particle_t        upd_wdata
);

  import ppu_pkg::*;

  localparam int CNT_W = $clog2(POOL + 1);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(POOL - 1);

  state_t                state_r, state_nxt;
  logic [PTR_W-1:0]      idx_r, idx_nxt;
  logic [PTR_W-1:0]      ptr_r, ptr_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [PTR_W-1:0]      slot_r, slot_nxt;
  logic                  rd_pend_r;
  logic [PTR_W-1:0]      rd_addr_r;
  logic                  out_valid_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic [COUNT_W-1:0]    out_cnt_r;

  logic                  req_r;
  logic [TS_W-1:0]       ts_r;
  logic [Q_W-1:0]        posx_r, posy_r, sprx_r, spry_r;
  logic [LIFE_W-1:0]     life_r;
  logic [ANG_STEP_W-1:0] ang_step_r;

  logic [TS_W+ANG_RECIP_W-1:0] ang_prod;
  logic                  accept;
  logic                  res_load;
  logic [PTR_W+SLOT_W-1:0]   slot_ext;
  logic [CNT_W+COUNT_W-1:0]  cnt_ext;
  particle_t             emit_rec;

  assign accept   = in_valid && !in_stall;
  assign res_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign ang_prod = ts_r * ANG_RECIP;

  always_comb begin
    emit_rec       = '0;
    emit_rec.alive = 1'b1;
    emit_rec.life  = {1'b0, life_r};
    emit_rec.pos_x = posx_r;
    emit_rec.pos_y = posy_r;
    emit_rec.spd_x = {sprx_r[Q_W-1], sprx_r[Q_W-1:1]};
    emit_rec.spd_y = {spry_r[Q_W-1], spry_r[Q_W-1:1]};
    emit_rec.angle = PI_Q16;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:   if (idx_r == LAST_IDX) state_nxt = ST_IDLE;
      ST_IDLE:    if (in_valid) state_nxt = (in_req_type == REQ_TICK) ? ST_TICK : ST_EMIT_RD;
      ST_EMIT_RD: state_nxt = ST_EMIT_WR;
      ST_EMIT_WR: state_nxt = ST_DONE;
      ST_TICK:    if (idx_r == LAST_IDX) state_nxt = ST_DRAIN;
      ST_DRAIN:   if (!rd_pend_r && !upd_stat.busy) state_nxt = ST_DONE;
      ST_DONE:    if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:    state_nxt = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = idx_r;
    idx_nxt   = idx_r;
    ptr_nxt   = ptr_r;
    slot_nxt  = slot_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we  = 1'b1;
        idx_nxt = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        idx_nxt  = '0;
      end
      ST_EMIT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = ptr_r;
      end
      ST_EMIT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ram_wdata = emit_rec;
        slot_nxt  = ptr_r;
        ptr_nxt   = (ptr_r == '0) ? LAST_IDX : ptr_r - 1'b1;
        if (!ram_rdata.alive) cnt_nxt = cnt_r + 1'b1;
      end
      ST_TICK: begin
        ram_we    = upd_stat.wr;
        ram_waddr = upd_waddr;
        ram_wdata = upd_wdata;
        ram_re    = 1'b1;
        slot_nxt  = '0;
        idx_nxt   = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
        if (upd_stat.retire) cnt_nxt = cnt_r - 1'b1;
      end
      ST_DRAIN: begin
        ram_we    = upd_stat.wr;
        ram_waddr = upd_waddr;
        ram_wdata = upd_wdata;
        slot_nxt  = '0;
        if (upd_stat.retire) cnt_nxt = cnt_r - 1'b1;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      ptr_r       <= '0;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      ptr_r     <= ptr_nxt;
      cnt_r     <= cnt_nxt;
      rd_pend_r <= (state_r == ST_TICK);
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign slot_ext = {{SLOT_W{1'b0}}, slot_r};
  assign cnt_ext  = {{COUNT_W{1'b0}}, cnt_r};

  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    rd_addr_r  <= idx_r;
    ang_step_r <= ang_prod[ANG_SHIFT +: ANG_STEP_W];
    if (accept) begin
      req_r  <= in_req_type;
      ts_r   <= in_timestep;
      posx_r <= in_pos_x;
      posy_r <= in_pos_y;
      sprx_r <= in_spread_x;
      spry_r <= in_spread_y;
      life_r <= in_life_span;
    end
    if (res_load) begin
      out_slot_r <= (req_r == REQ_EMIT) ? slot_ext[SLOT_W-1:0] : '0;
      out_cnt_r  <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign upd_cmd.lookup   = rd_pend_r;
  assign upd_cmd.ts       = ts_r;
  assign upd_cmd.ang_step = ang_step_r;
  assign upd_addr         = rd_addr_r;

  assign out_valid        = out_valid_r;
  assign out_slot_written = out_slot_r;
  assign out_live_count   = out_cnt_r;

endmodule

// File: hw/rtl/particle_pool_update.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// particle_pool_update
// Ring-allocated particle pool held in one memory; emit fills a slot, tick
// ages and moves every live particle.
//
//   port group  direction  handshake           contents
//   in_*        in         in_valid/in_stall   request type, timestep, emit data
//   out_*       out        out_valid/out_stall slot written, live count
//
// Emit: read of the slot, write-back, result load.
// Tick: a sweep with one memory read per cycle, then the update pipe drains.
// Reset: clearing pass over the memory, in_stall high throughout.
// A result waits in the output register; the next item is taken meanwhile and
// only its completion holds while out_stall is high.
// ---------------------------------------------------------------------------
module particle_pool_update #(
  parameter int POOL = ppu_pkg::POOL_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_req_type,
  input  logic [ppu_pkg::TS_W-1:0]     in_timestep,
  input  logic signed [ppu_pkg::Q_W-1:0] in_pos_x,
  input  logic signed [ppu_pkg::Q_W-1:0] in_pos_y,
  input  logic signed [ppu_pkg::Q_W-1:0] in_spread_x,
  input  logic signed [ppu_pkg::Q_W-1:0] in_spread_y,
  input  logic [ppu_pkg::LIFE_W-1:0]   in_life_span,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ppu_pkg::SLOT_W-1:0]   out_slot_written,
  output logic [ppu_pkg::COUNT_W-1:0]  out_live_count
);

  import ppu_pkg::*;

  localparam int PTR_W = $clog2(POOL);

  logic             ram_we, ram_re;
  logic [PTR_W-1:0] ram_waddr, ram_raddr;
  particle_t        ram_wdata, ram_rdata;
  logic [REC_W-1:0] ram_rdata_raw;
  upd_cmd_t         upd_cmd;
  upd_stat_t        upd_stat;
  logic [PTR_W-1:0] upd_addr, upd_waddr;
  particle_t        upd_wdata;

  ppu_ram #(
    .WIDTH (REC_W),
    .DEPTH (POOL)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = particle_t'(ram_rdata_raw);

  ppu_update #(
    .POOL (POOL)
  ) u_update (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (upd_cmd),
    .addr    (upd_addr),
    .rd_data (ram_rdata),
    .stat    (upd_stat),
    .waddr   (upd_waddr),
    .wdata   (upd_wdata)
  );

  ppu_ctrl #(
    .POOL (POOL)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_timestep      (in_timestep),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_spread_x      (in_spread_x),
    .in_spread_y      (in_spread_y),
    .in_life_span     (in_life_span),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_slot_written (out_slot_written),
    .out_live_count   (out_live_count),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_re           (ram_re),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .upd_cmd          (upd_cmd),
    .upd_addr         (upd_addr),
    .upd_stat         (upd_stat),
    .upd_waddr        (upd_waddr),
    .upd_wdata        (upd_wdata)
  );

  // an accepted transaction closes the input until its work is done
  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted on consecutive cycles");

  // no memory write is pending when a new transaction is taken
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !ram_we && !upd_stat.busy)
    else $error("memory write while accepting a transaction");

  // a retired particle is always written back
  a_retire_wr: assert property (@(posedge clk) disable iff (!rst_n)
    upd_stat.retire |-> upd_stat.wr && ram_we)
    else $error("particle retired without write-back");

endmodule

// File: sim/particle_pool_update_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// particle_pool_update_tb
// Self-checking bench for the particle pool. A scoreboard tracks which slots
// are live, their remaining life and the ring pointer. It predicts the slot
// and live count of every accepted transaction and checks each result in
// order. Stimulus runs in three parts. A directed part covers the field
// extremes, retirement at and below zero life and saturating moves. A run
// of emits fills a good part of the pool. A random mix of emits and ticks
// follows. Random sender bursts and receiver stalls run throughout, with
// one long receiver hold-off.
// ---------------------------------------------------------------------------
module particle_pool_update_tb;
  import ppu_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int HOLD_CYCLES = 400;
  localparam int FILL_EMITS  = 300;
  localparam int RAND_ITEMS  = 250;
  localparam logic [LIFE_W-1:0] MAX_LIFE = {LIFE_W{1'b1}};

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

  // Only liveness and remaining life reach the outputs; positions, speeds
  // and angles never feed back into them.
  class pool_tracker_t;
    bit                    alive [POOL_DEF];
    logic signed [Q_W-1:0] life  [POOL_DEF];
    logic [SLOT_W-1:0]     ring_ptr;
    int unsigned           live_total;
    logic [SLOT_W-1:0]     due_slot [$];
    logic [COUNT_W-1:0]    due_live [$];
    int                    errors;

    function new();
      ring_ptr   = '0;
      live_total = 0;
      errors     = 0;
    endfunction

    function int pending();
      return due_slot.size();
    endfunction

    function void apply_request(input logic req, input logic [TS_W-1:0] ts,
                                input logic [LIFE_W-1:0] span);
      logic [SLOT_W-1:0] slot;
      int i;
      slot = '0;
      if (req == REQ_EMIT) begin
        slot = ring_ptr;
        if (!alive[slot]) live_total++;
        alive[slot] = 1'b1;
        life[slot]  = {1'b0, span};
        ring_ptr    = (slot == '0) ? SLOT_W'(POOL_DEF - 1) : slot - 1'b1;
      end else begin
        for (i = 0; i < POOL_DEF; i++) begin
          if (alive[i]) begin
            if (life[i] <= 0) begin
              alive[i] = 1'b0;
              live_total--;
            end else begin
              life[i] = life[i] - $signed({1'b0, ts});
            end
          end
        end
      end
      due_slot.push_back(slot);
      due_live.push_back(COUNT_W'(live_total));
    endfunction

    function void match_result(input logic [SLOT_W-1:0] slot,
                               input logic [COUNT_W-1:0] live);
      logic [SLOT_W-1:0]  want_slot;
      logic [COUNT_W-1:0] want_live;
      if (due_slot.size() == 0) begin
        $error("unexpected result: slot_written %0d live_count %0d", slot, live);
        errors++;
        return;
      end
      want_slot = due_slot.pop_front();
      want_live = due_live.pop_front();
      if (slot !== want_slot) begin
        $error("slot_written: expected %0d, actual %0d", want_slot, slot);
        errors++;
      end
      if (live !== want_live) begin
        $error("live_count: expected %0d, actual %0d", want_live, live);
        errors++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_req_type;
  logic [TS_W-1:0]         in_timestep;
  logic signed [Q_W-1:0]   in_pos_x;
  logic signed [Q_W-1:0]   in_pos_y;
  logic signed [Q_W-1:0]   in_spread_x;
  logic signed [Q_W-1:0]   in_spread_y;
  logic [LIFE_W-1:0]       in_life_span;
  logic                    out_valid;
  logic                    out_stall;
  logic [SLOT_W-1:0]       out_slot_written;
  logic [COUNT_W-1:0]      out_live_count;

  pool_tracker_t tracker;
  int            burst_left;
  bit            hold_req;
  int            cycle_count;

  particle_pool_update #(.POOL(POOL_DEF)) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_timestep      (in_timestep),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_spread_x      (in_spread_x),
    .in_spread_y      (in_spread_y),
    .in_life_span     (in_life_span),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_slot_written (out_slot_written),
    .out_live_count   (out_live_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        tracker.apply_request(in_req_type, in_timestep, in_life_span);
      if (out_valid && !out_stall)
        tracker.match_result(out_slot_written, out_live_count);
    end
  end

  // receiver: random stall modes, plus one long hold-off on request
  initial begin
    stall_mode_t mode;
    int          mode_left;
    mode      = STALL_NONE;
    mode_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(10, 300);
        end
        mode_left--;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          default:     out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic send_request(input logic req, input logic [TS_W-1:0] ts,
                              input logic signed [Q_W-1:0] px,
                              input logic signed [Q_W-1:0] py,
                              input logic signed [Q_W-1:0] sx,
                              input logic signed [Q_W-1:0] sy,
                              input logic [LIFE_W-1:0] span);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_timestep  <= ts;
    in_pos_x     <= px;
    in_pos_y     <= py;
    in_spread_x  <= sx;
    in_spread_y  <= sy;
    in_life_span <= span;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random(input logic req, input logic [LIFE_W-1:0] span);
    logic [TS_W-1:0] ts;
    case ($urandom_range(0, 2))
      0:       ts = TS_W'($urandom);
      1:       ts = TS_W'($urandom_range(20000, 65535));
      default: ts = TS_W'($urandom_range(0, 1000));
    endcase
    send_request(req, ts, $urandom, $urandom, $urandom, $urandom, span);
  endtask

  initial begin
    logic              req;
    logic [LIFE_W-1:0] span;
    int                n;
    tracker      = new();
    burst_left   = 0;
    hold_req     = 1'b0;
    cycle_count  = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req_type  = REQ_EMIT;
    in_timestep  = '0;
    in_pos_x     = '0;
    in_pos_y     = '0;
    in_spread_x  = '0;
    in_spread_y  = '0;
    in_life_span = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed: tick on empty pool, field extremes, retirement, saturation
    send_request(REQ_TICK, 16'hFFFF, '1, '1, '1, '1, MAX_LIFE);
    send_request(REQ_EMIT, 16'h0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                 32'sh8000_0000, 32'sh7FFF_FFFF, '0);
    send_request(REQ_EMIT, 16'hFFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                 32'sh7FFF_FFFF, 32'sh8000_0000, MAX_LIFE);
    send_request(REQ_EMIT, 16'h1234, '0, '0, -32'sd1, -32'sd3, 31'd1);
    send_request(REQ_EMIT, 16'h0000, 32'sd65536, -32'sd65536, 32'sd1, 32'sd0,
                 31'd65535);
    send_request(REQ_EMIT, 16'h0000, -32'sd1, 32'sd1, -32'sd2, 32'sd2, 31'd65536);
    send_request(REQ_TICK, 16'hFFFF, '0, '0, '0, '0, '0);
    send_request(REQ_TICK, 16'h0000, '0, '0, '0, '0, '0);
    send_request(REQ_TICK, 16'd1, '0, '0, '0, '0, '0);
    send_request(REQ_TICK, 16'd100, '0, '0, '0, '0, '0);
    send_request(REQ_EMIT, 16'h0000, 32'sh7FFF_0000, 32'sh8000_FFFF,
                 32'sh7FFF_FFFF, 32'sh8000_0000, 31'd262144);
    send_request(REQ_EMIT, 16'h0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                 32'sh8000_0001, 32'sh7FFF_FFFE, 31'd131072);
    send_request(REQ_TICK, 16'hFFFF, '0, '0, '0, '0, '0);
    send_request(REQ_TICK, 16'hFFFF, '0, '0, '0, '0, '0);
    send_request(REQ_TICK, 16'd99, '0, '0, '0, '0, '0);
    send_request(REQ_TICK, 16'h8000, '0, '0, '0, '0, '0);

    // fill: a long run of emits
    for (n = 0; n < FILL_EMITS; n++)
      send_random(REQ_EMIT, LIFE_W'($urandom_range(1, 200000)));

    // long receiver hold-off while emits keep coming, back to back
    hold_req   = 1'b1;
    burst_left = 12;
    for (n = 0; n < 12; n++)
      send_random(REQ_EMIT, LIFE_W'($urandom_range(0, 400000)));

    for (n = 0; n < RAND_ITEMS; n++) begin
      req = ($urandom_range(0, 3) == 0) ? REQ_TICK : REQ_EMIT;
      case ($urandom_range(0, 7))
        0:       span = '0;
        1:       span = LIFE_W'($urandom);
        default: span = LIFE_W'($urandom_range(0, 400000));
      endcase
      send_random(req, span);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (tracker.pending() > 0) @(posedge clk);
    repeat (POOL_DEF + 20) @(posedge clk);
    if (tracker.pending() > 0) begin
      $error("%0d results never arrived", tracker.pending());
      tracker.errors++;
    end
    if (tracker.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/ppu_pkg.sv
hw/rtl/ppu_ram.sv
hw/rtl/ppu_update.sv
hw/rtl/ppu_ctrl.sv
hw/rtl/particle_pool_update.sv
sim/particle_pool_update_tb.sv
